// ===== rtl/core/ssg_pkg.sv =====
package ssg_pkg;

    // defaults for the top-level parameters
    localparam int HISTORY_DEPTH_DEF = 16;
    localparam int WEIGHT_BITS_DEF   = 24;

    // fixed field widths
    localparam int TIME_BITS     = 32;
    localparam int WIN_BITS      = 16;
    localparam int HLEN_BITS     = 5;
    localparam int STEP_BITS     = 23;
    localparam int RCNT_BITS     = 16;
    localparam int RATE_BITS     = 32;
    localparam int QUO_BITS      = 33;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 23;

    // register reset values
    localparam logic [HLEN_BITS-1:0] HLEN_RST = 5'd16;
    localparam logic [STEP_BITS-1:0] STEP_RST = '0;
    localparam logic [WIN_BITS-1:0]  WIN_RST  = 16'd1000;
    localparam logic [WIN_BITS-1:0]  HOLD_RST = 16'd500;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_HISTORY_LEN = 2'd0,
        CFG_MAX_STEP    = 2'd1,
        CFG_RATE_WINDOW = 2'd2,
        CFG_HOLD_TIME   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [HLEN_BITS-1:0] history_len;
        logic [STEP_BITS-1:0] max_step;
        logic [WIN_BITS-1:0]  rate_window;
        logic [WIN_BITS-1:0]  hold_time;
        logic                 hlen_written;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GATE,
        ST_FSET,
        ST_RADDR,
        ST_RLOAD,
        ST_ACC,
        ST_MSET,
        ST_MUL,
        ST_PREP,
        ST_DIVGO,
        ST_DIV,
        ST_FIN
    } back_state_t;

    typedef struct packed {
        logic ram_we;
        logic take;
        logic div_start;
    } back_ctl_t;

endpackage

// ===== rtl/core/ssg_ram.sv =====
module ssg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/ssg_front.sv =====
module ssg_front #(
    parameter int WEIGHT_BITS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           operation,
    input  logic signed [WEIGHT_BITS-1:0]  sample_grams,
    input  logic [ssg_pkg::TIME_BITS-1:0]  sample_time,
    input  logic                           sample_stable,
    input  logic                           sample_finite,
    input  logic [ssg_pkg::TIME_BITS-1:0]  query_time,
    output logic                           item_valid,
    input  logic                           take,
    output logic                           item_push,
    output logic signed [WEIGHT_BITS-1:0]  item_grams,
    output logic [ssg_pkg::TIME_BITS-1:0]  item_time,
    output logic                           item_stable,
    output logic                           item_finite,
    output logic [ssg_pkg::TIME_BITS-1:0]  item_qtime
);
    import ssg_pkg::*;

    // two-entry request queue; entries tagged push or query on entry
    logic                   is_push_reg [2];
    logic [WEIGHT_BITS-1:0] grams_reg   [2];
    logic [TIME_BITS-1:0]   time_reg    [2];
    logic                   stable_reg  [2];
    logic                   finite_reg  [2];
    logic [TIME_BITS-1:0]   qtime_reg   [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_en;

    assign full       = (cnt_reg == 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign wr_en      = push && !full;

    always_comb
    begin
        wr_ptr_next = wr_en ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take  ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(wr_en) - 2'(take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            is_push_reg[wr_ptr_reg] <= !operation;
            grams_reg[wr_ptr_reg]   <= sample_grams;
            time_reg[wr_ptr_reg]    <= sample_time;
            stable_reg[wr_ptr_reg]  <= sample_stable;
            finite_reg[wr_ptr_reg]  <= sample_finite;
            qtime_reg[wr_ptr_reg]   <= query_time;
        end
    end

    assign item_push   = is_push_reg[rd_ptr_reg];
    assign item_grams  = grams_reg[rd_ptr_reg];
    assign item_time   = time_reg[rd_ptr_reg];
    assign item_stable = stable_reg[rd_ptr_reg];
    assign item_finite = finite_reg[rd_ptr_reg];
    assign item_qtime  = qtime_reg[rd_ptr_reg];
endmodule

// ===== rtl/core/ssg_div.sv =====
module ssg_div #(
    parameter int AW   = 80,
    parameter int DENW = 43
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [AW-1:0]                   dividend,
    input  logic [DENW-1:0]                 divisor,
    output logic                            done,
    output logic                            ovf,
    output logic [ssg_pkg::QUO_BITS-1:0]    quo
);
    import ssg_pkg::*;

    localparam int HW   = AW - QUO_BITS;
    localparam int CMPW = (HW > DENW) ? HW : DENW;
    localparam int CNTW = $clog2(QUO_BITS + 1);

    // restoring divide, one quotient bit a cycle
    logic                busy_reg;
    logic [CNTW-1:0]     cnt_reg;
    logic [DENW-1:0]     rem_reg;
    logic [QUO_BITS-1:0] low_reg;
    logic [QUO_BITS-1:0] quo_reg;
    logic                ovf_reg;
    logic                done_reg;
    logic                hi_ovf;
    logic [DENW:0]       trial;
    logic                fits;

    assign hi_ovf = CMPW'(dividend[AW-1:QUO_BITS]) >= CMPW'(divisor);
    assign trial  = {rem_reg, low_reg[QUO_BITS-1]};
    assign fits   = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= !hi_ovf;
                done_reg <= hi_ovf;
                cnt_reg  <= CNTW'(QUO_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ovf_reg <= hi_ovf;
            rem_reg <= DENW'(dividend[AW-1:QUO_BITS]);
            low_reg <= dividend[QUO_BITS-1:0];
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DENW'(trial - {1'b0, divisor}) : trial[DENW-1:0];
            low_reg <= {low_reg[QUO_BITS-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_BITS-2:0], fits};
        end
    end

    assign done = done_reg;
    assign ovf  = ovf_reg;
    assign quo  = quo_reg;
endmodule

// ===== rtl/core/ssg_back.sv =====
module ssg_back #(
    parameter int HISTORY_DEPTH = 16,
    parameter int WEIGHT_BITS   = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ssg_pkg::cfg_t                     cfg,
    input  logic                              item_valid,
    output logic                              take,
    input  logic                              item_push,
    input  logic signed [WEIGHT_BITS-1:0]     item_grams,
    input  logic [ssg_pkg::TIME_BITS-1:0]     item_time,
    input  logic                              item_stable,
    input  logic                              item_finite,
    input  logic [ssg_pkg::TIME_BITS-1:0]     item_qtime,
    input  logic                              pop,
    output logic                              empty,
    output logic                              accepted,
    output logic [ssg_pkg::RCNT_BITS-1:0]     reject_count,
    output logic signed [WEIGHT_BITS:0]       rejected_step,
    output logic signed [WEIGHT_BITS-1:0]     latest_grams,
    output logic                              latest_stable,
    output logic signed [ssg_pkg::RATE_BITS-1:0] weight_slope,
    output logic [ssg_pkg::TIME_BITS-1:0]     data_age,
    output logic                              settled,
    output logic [$clog2(HISTORY_DEPTH+1)-1:0] history_fill
);
    import ssg_pkg::*;

    localparam int W     = WEIGHT_BITS;
    localparam int AWID  = $clog2(HISTORY_DEPTH);
    localparam int CW    = $clog2(HISTORY_DEPTH + 1);
    localparam int DW    = WIN_BITS;
    localparam int SDW   = DW + CW;
    localparam int SDDW  = 2 * DW + CW;
    localparam int SWW   = W + CW;
    localparam int SDWW  = DW + W + 1 + CW;
    localparam int NUMW  = DW + W + 2 * CW + 2;
    localparam int DENW  = 2 * DW + 2 * CW + 1;
    localparam int AW    = NUMW + 17;
    localparam int MULN  = SDW;
    localparam int MCNTW = $clog2(MULN + 1);
    localparam int CMPW  = (W + 1 > STEP_BITS) ? W + 1 : STEP_BITS;
    localparam logic [RATE_BITS-1:0] POS_LIM = {1'b0, {(RATE_BITS-1){1'b1}}};
    localparam logic [RATE_BITS-1:0] NEG_LIM = {1'b1, {(RATE_BITS-1){1'b0}}};

    back_state_t state_reg, state_next;
    back_ctl_t   ctl;

    // gate state
    logic [AWID-1:0]       head_reg;
    logic [CW-1:0]         count_reg;
    logic                  nstable_reg;
    logic [TIME_BITS-1:0]  change_reg;
    logic [RCNT_BITS-1:0]  rcnt_reg;
    logic signed [W:0]     lstep_reg;
    logic signed [W-1:0]   nw_reg;
    logic [TIME_BITS-1:0]  nt_reg;
    logic                  acc_reg;

    // fit state
    logic [AWID-1:0]       rd_ptr_reg;
    logic [CW-1:0]         k_reg;
    logic [CW-1:0]         n_reg;
    logic [SDW-1:0]        sd_reg;
    logic [SDDW-1:0]       sdd_reg;
    logic signed [SWW-1:0] sw_reg;
    logic signed [SDWW-1:0] sdw_reg;
    logic [DW-1:0]         d_reg;
    logic signed [W-1:0]   w_reg;
    logic                  inwin_reg;

    // product sums
    logic [MCNTW-1:0]       mcnt_reg;
    logic [SDW-1:0]         mr_sd_reg;
    logic [SDW-1:0]         mr_n_reg;
    logic signed [NUMW-1:0] mc_sw_reg, mc_dw_reg, num_reg;
    logic signed [DENW-1:0] mc_sd_reg, mc_sdd_reg, den_reg;

    logic [AW-1:0]          a_reg;
    logic                   neg_reg;
    logic [RATE_BITS-1:0]   rate_reg;

    // result register
    logic                   o_valid_reg;
    logic                   o_acc_reg;
    logic [RCNT_BITS-1:0]   o_rcnt_reg;
    logic signed [W:0]      o_step_reg;
    logic signed [W-1:0]    o_latest_reg;
    logic                   o_lst_reg;
    logic [RATE_BITS-1:0]   o_rate_reg;
    logic [TIME_BITS-1:0]   o_age_reg;
    logic                   o_set_reg;
    logic [CW-1:0]          o_fill_reg;

    // ring memory, weight above stamp
    logic [W+TIME_BITS-1:0] ram_rdata;
    logic [TIME_BITS-1:0]   rd_time;
    logic signed [W-1:0]    rd_w;

    logic                   div_done, div_ovf;
    logic [QUO_BITS-1:0]    div_quo;

    logic [CW-1:0]          eff_len;
    logic signed [W:0]      step;
    logic [W:0]             mag;
    logic                   step_bad, stamp_bad, gate_ok;
    logic [AWID-1:0]        head_inc, rd_dec;
    logic [TIME_BITS-1:0]   d_full;
    logic signed [SDWW-1:0] prod_dw;
    logic [SDDW-1:0]        prod_dd;
    logic [NUMW-1:0]        num_mag;
    logic [AW-1:0]          a125;
    logic                   out_free;
    logic [QUO_BITS-1:0]    lim;
    logic [RATE_BITS-1:0]   val;

    ssg_ram #(
        .WIDTH (W + TIME_BITS),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ctl.ram_we),
        .waddr (head_reg),
        .wdata ({item_grams, item_time}),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    ssg_div #(
        .AW   (AW),
        .DENW (DENW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (a_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .ovf      (div_ovf),
        .quo      (div_quo)
    );

    assign rd_time = ram_rdata[TIME_BITS-1:0];
    assign rd_w    = ram_rdata[W+TIME_BITS-1:TIME_BITS];

    always_comb
    begin
        if (cfg.history_len < HLEN_BITS'(2))
            eff_len = CW'(2);
        else if (int'(cfg.history_len) > HISTORY_DEPTH)
            eff_len = CW'(HISTORY_DEPTH);
        else
            eff_len = CW'(cfg.history_len);
    end

    // sample gate
    always_comb
    begin
        step      = (W+1)'(item_grams) - (W+1)'(nw_reg);
        mag       = step[W] ? (W+1)'(-step) : (W+1)'(step);
        step_bad  = (count_reg != '0) && (cfg.max_step != '0)
                    && (CMPW'(mag) > CMPW'(cfg.max_step));
        stamp_bad = (count_reg != '0) && (item_time <= nt_reg);
        gate_ok   = item_push && item_finite && !step_bad && !stamp_bad;
        head_inc  = (int'(head_reg) == HISTORY_DEPTH - 1) ? '0 : head_reg + 1'b1;
        rd_dec    = (rd_ptr_reg == '0) ? AWID'(HISTORY_DEPTH - 1) : rd_ptr_reg - 1'b1;
    end

    // fit datapath
    always_comb
    begin
        d_full  = nt_reg - rd_time;
        prod_dw = $signed({1'b0, d_reg}) * w_reg;
        prod_dd = d_reg * d_reg;
        num_mag = num_reg[NUMW-1] ? NUMW'(-num_reg) : NUMW'(num_reg);
        a125    = (AW'(num_mag) << 7) - (AW'(num_mag) << 2) + AW'(num_mag);
        lim     = neg_reg ? QUO_BITS'(NEG_LIM) : QUO_BITS'(POS_LIM);
        val     = (div_ovf || (div_quo > lim)) ? lim[RATE_BITS-1:0]
                                               : div_quo[RATE_BITS-1:0];
        out_free = !o_valid_reg || pop;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (item_valid) state_next = ST_GATE;
            ST_GATE:  state_next = ST_FSET;
            ST_FSET:  state_next = (count_reg < CW'(2)) ? ST_FIN : ST_RADDR;
            ST_RADDR: state_next = ST_RLOAD;
            ST_RLOAD: state_next = ST_ACC;
            ST_ACC:   state_next = (k_reg == '0) ? ST_MSET : ST_RADDR;
            ST_MSET:  state_next = (n_reg < CW'(2)) ? ST_FIN : ST_MUL;
            ST_MUL:   if (mcnt_reg == MCNTW'(1)) state_next = ST_PREP;
            ST_PREP:  state_next = (den_reg <= 0) ? ST_FIN : ST_DIVGO;
            ST_DIVGO: state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_FIN;
            ST_FIN:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control strobes
    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            ST_GATE:  ctl.ram_we    = gate_ok;
            ST_DIVGO: ctl.div_start = 1'b1;
            ST_FIN:   ctl.take      = out_free;
            default:  ctl = '0;
        endcase
    end

    assign take = ctl.take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            nstable_reg <= 1'b0;
            change_reg  <= '0;
            rcnt_reg    <= '0;
            lstep_reg   <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.hlen_written && (count_reg > eff_len))
            begin
                count_reg <= eff_len;
            end
            if (state_reg == ST_GATE && item_push)
            begin
                if (gate_ok)
                begin
                    head_reg    <= head_inc;
                    count_reg   <= (count_reg < eff_len) ? count_reg + 1'b1 : eff_len;
                    nstable_reg <= item_stable;
                    rcnt_reg    <= '0;
                    lstep_reg   <= '0;
                    if ((count_reg == '0) || (item_grams != nw_reg))
                    begin
                        change_reg <= item_time;
                    end
                end
                else
                begin
                    if (rcnt_reg != '1)
                    begin
                        rcnt_reg <= rcnt_reg + 1'b1;
                    end
                    if (item_finite && step_bad)
                    begin
                        lstep_reg <= step;
                    end
                end
            end
            if (ctl.take)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_GATE:
            begin
                acc_reg <= gate_ok;
                if (gate_ok)
                begin
                    nw_reg <= item_grams;
                    nt_reg <= item_time;
                end
            end
            ST_FSET:
            begin
                rd_ptr_reg <= (head_reg == '0) ? AWID'(HISTORY_DEPTH - 1) : head_reg - 1'b1;
                k_reg      <= count_reg;
                n_reg      <= '0;
                sd_reg     <= '0;
                sdd_reg    <= '0;
                sw_reg     <= '0;
                sdw_reg    <= '0;
                rate_reg   <= '0;
            end
            ST_RLOAD:
            begin
                d_reg      <= d_full[DW-1:0];
                w_reg      <= rd_w;
                inwin_reg  <= d_full <= TIME_BITS'(cfg.rate_window);
                rd_ptr_reg <= rd_dec;
                k_reg      <= k_reg - 1'b1;
            end
            ST_ACC:
            begin
                if (inwin_reg)
                begin
                    n_reg   <= n_reg + 1'b1;
                    sd_reg  <= sd_reg + SDW'(d_reg);
                    sdd_reg <= sdd_reg + prod_dd;
                    sw_reg  <= sw_reg + SWW'(w_reg);
                    sdw_reg <= sdw_reg + prod_dw;
                end
            end
            ST_MSET:
            begin
                mcnt_reg   <= MCNTW'(MULN);
                mr_sd_reg  <= sd_reg;
                mr_n_reg   <= SDW'(n_reg);
                mc_sw_reg  <= NUMW'(sw_reg);
                mc_dw_reg  <= NUMW'(sdw_reg);
                mc_sd_reg  <= DENW'(sd_reg);
                mc_sdd_reg <= DENW'(sdd_reg);
                num_reg    <= '0;
                den_reg    <= '0;
                rate_reg   <= '0;
            end
            ST_MUL:
            begin
                // num = sd*sw - n*sdw, den = n*sdd - sd*sd
                num_reg    <= num_reg + (mr_sd_reg[0] ? mc_sw_reg : '0)
                                      - (mr_n_reg[0] ? mc_dw_reg : '0);
                den_reg    <= den_reg + (mr_n_reg[0] ? mc_sdd_reg : '0)
                                      - (mr_sd_reg[0] ? mc_sd_reg : '0);
                mc_sw_reg  <= mc_sw_reg <<< 1;
                mc_dw_reg  <= mc_dw_reg <<< 1;
                mc_sd_reg  <= mc_sd_reg <<< 1;
                mc_sdd_reg <= mc_sdd_reg <<< 1;
                mr_sd_reg  <= mr_sd_reg >> 1;
                mr_n_reg   <= mr_n_reg >> 1;
                mcnt_reg   <= mcnt_reg - 1'b1;
            end
            ST_PREP:
            begin
                // times 256000 = 125 << 11
                neg_reg <= num_reg[NUMW-1];
                a_reg   <= a125 << 11;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    rate_reg <= neg_reg ? RATE_BITS'(-val) : val;
                end
            end
            default:
            begin
            end
        endcase
        if (ctl.take)
        begin
            o_acc_reg    <= acc_reg && item_push;
            o_rcnt_reg   <= rcnt_reg;
            o_step_reg   <= lstep_reg;
            o_fill_reg   <= count_reg;
            o_rate_reg   <= rate_reg;
            o_latest_reg <= (count_reg != '0) ? nw_reg : '0;
            o_lst_reg    <= (count_reg != '0) && nstable_reg;
            o_age_reg    <= (count_reg == '0) ? '1
                          : (item_qtime >= nt_reg) ? item_qtime - nt_reg : '0;
            o_set_reg    <= (count_reg != '0) && nstable_reg
                            && (item_qtime >= change_reg)
                            && ((item_qtime - change_reg) >= TIME_BITS'(cfg.hold_time));
        end
    end

    assign empty         = !o_valid_reg;
    assign accepted      = o_acc_reg;
    assign reject_count  = o_rcnt_reg;
    assign rejected_step = o_step_reg;
    assign latest_grams  = o_latest_reg;
    assign latest_stable = o_lst_reg;
    assign weight_slope  = o_rate_reg;
    assign data_age      = o_age_reg;
    assign settled       = o_set_reg;
    assign history_fill  = o_fill_reg;
endmodule

// ===== rtl/core/scale_sample_gate_flow_rate.sv =====
// Scale sample gate with flow-rate fit. Requests enter through a two-entry
// queue (push/full) and results leave through a one-entry result register
// (empty/pop), so the input side keeps taking requests while a finished
// result waits. Each request is handled by a sequencer one at a time: a
// gate step that checks the sample and updates the history ring, a read
// of each held entry from the ring memory (single registered read port)
// with accumulation of the fit sums, shift-add multiplication for
// numerator and denominator, a scaling step, and a 33-step restoring
// divide. An empty or one-entry ring, or a window holding fewer than two
// entries, finishes early and skips the multiply and divide.
// There is no clearing pass after reset; the fill count guards the ring.
// Configuration writes are always ready and must only be issued while no
// request is outstanding.
module scale_sample_gate_flow_rate #(
    parameter int HISTORY_DEPTH = ssg_pkg::HISTORY_DEPTH_DEF,
    parameter int WEIGHT_BITS   = ssg_pkg::WEIGHT_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // request side
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  operation,
    input  logic signed [WEIGHT_BITS-1:0]         sample_grams,
    input  logic [ssg_pkg::TIME_BITS-1:0]         sample_time,
    input  logic                                  sample_stable,
    input  logic                                  sample_finite,
    input  logic [ssg_pkg::TIME_BITS-1:0]         query_time,
    // result side
    output logic                                  empty,
    input  logic                                  pop,
    output logic                                  accepted,
    output logic [ssg_pkg::RCNT_BITS-1:0]         reject_count,
    output logic signed [WEIGHT_BITS:0]           rejected_step,
    output logic signed [WEIGHT_BITS-1:0]         latest_grams,
    output logic                                  latest_stable,
    output logic signed [ssg_pkg::RATE_BITS-1:0]  weight_slope,
    output logic [ssg_pkg::TIME_BITS-1:0]         data_age,
    output logic                                  settled,
    output logic [$clog2(HISTORY_DEPTH+1)-1:0]    history_fill,
    // configuration
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ssg_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [ssg_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import ssg_pkg::*;

    logic [HLEN_BITS-1:0] hlen_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic [WIN_BITS-1:0]  win_reg;
    logic [WIN_BITS-1:0]  hold_reg;
    logic                 hlen_wr_reg;
    logic                 cfg_wr;
    cfg_t                 cfg;

    logic                          item_valid, item_take, item_push;
    logic signed [WEIGHT_BITS-1:0] item_grams;
    logic [TIME_BITS-1:0]          item_time, item_qtime;
    logic                          item_stable, item_finite;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // Register file. A history length write clamps the fill count in the next
    // cycle, once the new length is in place.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hlen_reg    <= HLEN_RST;
            step_reg    <= STEP_RST;
            win_reg     <= WIN_RST;
            hold_reg    <= HOLD_RST;
            hlen_wr_reg <= 1'b0;
        end
        else
        begin
            hlen_wr_reg <= 1'b0;
            if (cfg_wr)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_HISTORY_LEN:
                    begin
                        hlen_reg    <= cfg_data[HLEN_BITS-1:0];
                        hlen_wr_reg <= 1'b1;
                    end
                    CFG_MAX_STEP:    step_reg <= cfg_data[STEP_BITS-1:0];
                    CFG_RATE_WINDOW: win_reg  <= cfg_data[WIN_BITS-1:0];
                    CFG_HOLD_TIME:   hold_reg <= cfg_data[WIN_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        cfg.history_len  = hlen_reg;
        cfg.max_step     = step_reg;
        cfg.rate_window  = win_reg;
        cfg.hold_time    = hold_reg;
        cfg.hlen_written = hlen_wr_reg;
    end

    // front: request queue, tags each request as sample or query
    ssg_front #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .operation     (operation),
        .sample_grams  (sample_grams),
        .sample_time   (sample_time),
        .sample_stable (sample_stable),
        .sample_finite (sample_finite),
        .query_time    (query_time),
        .item_valid    (item_valid),
        .take          (item_take),
        .item_push     (item_push),
        .item_grams    (item_grams),
        .item_time     (item_time),
        .item_stable   (item_stable),
        .item_finite   (item_finite),
        .item_qtime    (item_qtime)
    );

    // back: gate, history ring, least-squares fit, divide, result register
    ssg_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .WEIGHT_BITS   (WEIGHT_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .item_valid    (item_valid),
        .take          (item_take),
        .item_push     (item_push),
        .item_grams    (item_grams),
        .item_time     (item_time),
        .item_stable   (item_stable),
        .item_finite   (item_finite),
        .item_qtime    (item_qtime),
        .pop           (pop),
        .empty         (empty),
        .accepted      (accepted),
        .reject_count  (reject_count),
        .rejected_step (rejected_step),
        .latest_grams  (latest_grams),
        .latest_stable (latest_stable),
        .weight_slope  (weight_slope),
        .data_age      (data_age),
        .settled       (settled),
        .history_fill  (history_fill)
    );

    // an accepted sample always clears the reject status
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && accepted) |-> (reject_count == '0 && rejected_step == '0))
        else $error("reject status not cleared on acceptance");

    // the ring never reports more entries than it holds
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (int'(history_fill) <= HISTORY_DEPTH))
        else $error("history fill beyond depth");

    // no slope without two held entries
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && history_fill < 2) |-> (weight_slope == '0))
        else $error("flow rate from fewer than two entries");

    // settled needs a stable newest sample
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && settled) |-> latest_stable)
        else $error("settled without stable sample");
endmodule
